// ===== rtl/core/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Shared widths, codes and sequencer states of the buddy tree allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

   localparam int BYTE_W     = 37;          // byte counts and offsets
   localparam int SAT_W      = BYTE_W + 1;  // size ladder with a saturation bit
   localparam int OFF_W      = BYTE_W + 2;  // running offsets before the fit check
   localparam int LVL_CFG_W  = 4;           // tree_levels register
   localparam int CSR_IDX_W  = 1;
   localparam int REM_CNT_W  = $clog2(BYTE_W);

   localparam logic [LVL_CFG_W-1:0] TREE_LEVELS_RST = 4'd8;
   localparam logic [BYTE_W-1:0]    POOL_BYTES_RST  = 37'd16777216;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TREE_LEVELS = 1'b0,
      REG_POOL_BYTES  = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHOOSE,
      ST_LEVEL,
      ST_DIV,
      ST_PREP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK_RD,
      ST_MARK_CHK,
      ST_BELOW,
      ST_FREE_UP,
      ST_FREE_CHK,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/bta_req_if.sv =====
// ----------------------------------------------------------------------------
// bta_req_if
// Request channel: allocate or free commands into the allocator.
// ----------------------------------------------------------------------------
interface bta_req_if #(
   parameter int NODE_W = 8
);
   import bta_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] request_bytes;
   logic [BYTE_W-1:0] align_bytes;
   logic [NODE_W-1:0] node_index;

   modport source (
      output valid, command, request_bytes, align_bytes, node_index,
      input  ready
   );

   modport sink (
      input  valid, command, request_bytes, align_bytes, node_index,
      output ready
   );

endinterface

// ===== rtl/core/bta_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bta_rsp_if
// Response channel: one beat per accepted command.
// ----------------------------------------------------------------------------
interface bta_rsp_if #(
   parameter int NODE_W = 8
);
   import bta_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic [BYTE_W-1:0] byte_offset;
   logic [NODE_W-1:0] granted_node;

   modport source (
      output valid, ok, byte_offset, granted_node,
      input  ready
   );

   modport sink (
      input  valid, ok, byte_offset, granted_node,
      output ready
   );

endinterface

// ===== rtl/core/bta_csr_if.sv =====
// ----------------------------------------------------------------------------
// bta_csr_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface bta_csr_if;
   import bta_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

// ===== rtl/core/bta_ram.sv =====
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bta_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bta_rem_unit.sv =====
// ----------------------------------------------------------------------------
// bta_rem_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bta_rem_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bta_pkg::BYTE_W-1:0] dividend,
   input  logic [bta_pkg::BYTE_W-1:0] divisor,
   output logic                      done,
   output logic [bta_pkg::BYTE_W-1:0] remainder
);
   import bta_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0]    dvd_ff, dvd_in;
   logic [BYTE_W-1:0]    dsr_ff, dsr_in;
   logic [BYTE_W-1:0]    rem_ff, rem_in;
   logic [BYTE_W:0]      trial;
   logic [BYTE_W:0]      diff;

   // shift in the next dividend bit, subtract when the divisor fits
   assign trial = {rem_ff, dvd_ff[BYTE_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = REM_CNT_W'(BYTE_W - 1);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0];
         dvd_in = {dvd_ff[BYTE_W-2:0], 1'b0};
         cnt_in = cnt_ff - REM_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/buddy_tree_allocator.sv =====
// Sequence: a free clears nodes on the way up while their buddy is free, then clears every
// descendant and closes. An allocate picks a level, then for each visited level waits on the
// remainder unit and scans its nodes, then marks the node and its ancestors up to the first
// busy one, marks every descendant and closes.
// Throughput: one command at a time; the next is taken once the current one has finished.
// Reset: tree_levels 8, pool_bytes 16777216, then a clearing pass over all 2^MAX_LEVELS entries.
// ----------------------------------------------------------------------------
// buddy_tree_allocator
// Buddy allocator over an implicit binary tree of busy bits held in a RAM,
// walked by a small sequencer with a single remainder unit.
// ----------------------------------------------------------------------------
module buddy_tree_allocator #(
   parameter int MAX_LEVELS = 8
) (
   input  logic      clock,
   input  logic      reset,
   bta_csr_if.sink   csr_bus,
   bta_req_if.sink   req_bus,
   bta_rsp_if.source rsp_bus
);
   import bta_pkg::*;

   localparam int NODE_W    = MAX_LEVELS;
   localparam int NW1       = NODE_W + 1;
   localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
   localparam int CMP_W     = (LVL_W > LVL_CFG_W) ? LVL_W : LVL_CFG_W;
   localparam int RAM_DEPTH = 1 << MAX_LEVELS;

   // --- configuration registers ---------------------------------------------
   logic [LVL_CFG_W-1:0] tree_levels_ff;
   logic [BYTE_W-1:0]    pool_bytes_ff;

   // --- sequencer state -----------------------------------------------------
   state_type         state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // command latched at accept
   cmd_type           cmd_ff, cmd_in;
   logic [BYTE_W-1:0] req_bytes_ff, req_bytes_in;
   logic [BYTE_W-1:0] align_ff, align_in;

   // level selection and scan
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [SAT_W-1:0]  sat_ff, sat_in;
   logic [BYTE_W-1:0] span_ff, span_in;
   logic [BYTE_W-1:0] rs_ff, rs_in;
   logic [BYTE_W-1:0] span_fl_ff, span_fl_in;
   logic [BYTE_W-1:0] al_m_rs_ff, al_m_rs_in;
   logic [OFF_W-1:0]  span_fl_al_ff, span_fl_al_in;
   logic [OFF_W-1:0]  base_end_ff, base_end_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [BYTE_W-1:0] slack_ff, slack_in;
   logic              any_free_ff, any_free_in;
   logic [NODE_W-1:0] n_ff, n_in;
   logic [NODE_W-1:0] last_ff, last_in;

   // tree walks
   logic [NODE_W-1:0] tgt_ff, tgt_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NW1-1:0]    lo_ff, lo_in;
   logic [NW1-1:0]    hi_ff, hi_in;
   logic [NW1-1:0]    k_ff, k_in;

   // pending result and output register
   logic              res_ok_ff, res_ok_in;
   logic [BYTE_W-1:0] res_off_ff, res_off_in;
   logic [NODE_W-1:0] res_node_ff, res_node_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [BYTE_W-1:0] rsp_off_ff, rsp_off_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;

   // --- datapath helpers ----------------------------------------------------
   logic [LVL_W-1:0]  levels;
   logic [NODE_W-1:0] nodes;
   logic [BYTE_W-1:0] leaf_bytes;
   logic [BYTE_W-1:0] span_sel;
   logic [NODE_W-1:0] level_first;
   logic [NODE_W-1:0] level_last;
   logic [NODE_W-1:0] parent;
   logic [NODE_W-1:0] buddy;
   logic              fits;
   logic              bump;
   logic [OFF_W-1:0]  off_next;
   logic [BYTE_W-1:0] slack_next;
   logic              free_seen;
   logic              accept;

   logic              ram_we;
   logic [NODE_W-1:0] ram_waddr;
   logic [0:0]        ram_wdata;
   logic [NODE_W-1:0] ram_raddr;
   logic [0:0]        ram_rdata;

   logic              div_start;
   logic              div_done;
   logic [BYTE_W-1:0] div_rem;

   assign accept = req_bus.valid && req_bus.ready;

   // Clamp the level count to 1 .. MAX_LEVELS.
   always_comb begin
      if (tree_levels_ff == '0) begin
         levels = LVL_W'(1);
      end else if (CMP_W'(tree_levels_ff) > CMP_W'(MAX_LEVELS)) begin
         levels = LVL_W'(MAX_LEVELS);
      end else begin
         levels = LVL_W'(tree_levels_ff);
      end
   end

   assign nodes       = NODE_W'((NW1'(1) << levels) - NW1'(1));
   assign leaf_bytes  = pool_bytes_ff >> (levels - LVL_W'(1));
   assign span_sel    = pool_bytes_ff >> lvl_ff;
   assign level_first = NODE_W'((NW1'(1) << lvl_ff) - NW1'(1));
   assign level_last  = NODE_W'((NW1'(1) << LVL_W'(lvl_ff + LVL_W'(1))) - NW1'(2));
   assign parent      = NODE_W'((cur_ff - NODE_W'(1)) >> 1);
   assign buddy       = cur_ff[0] ? NODE_W'(cur_ff + NODE_W'(1))
                                  : NODE_W'(cur_ff - NODE_W'(1));

   // Fit check: aligned start plus size must end inside the node.
   assign fits = (off_ff + OFF_W'(req_bytes_ff)) <= base_end_ff;

   // Step the rounded-up offset to the next node without a divide. slack is
   // the distance from the node base up to the aligned offset; rs is the
   // node span modulo the alignment, taken once per level.
   assign bump       = rs_ff > slack_ff;
   assign off_next   = off_ff + (bump ? span_fl_al_ff : OFF_W'(span_fl_ff));
   assign slack_next = bump ? BYTE_W'(slack_ff + al_m_rs_ff) : BYTE_W'(slack_ff - rs_ff);
   assign free_seen  = any_free_ff || !ram_rdata[0];

   // --- sequencer -----------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      req_bytes_in  = req_bytes_ff;
      align_in      = align_ff;
      lvl_in        = lvl_ff;
      sat_in        = sat_ff;
      span_in       = span_ff;
      rs_in         = rs_ff;
      span_fl_in    = span_fl_ff;
      al_m_rs_in    = al_m_rs_ff;
      span_fl_al_in = span_fl_al_ff;
      base_end_in   = base_end_ff;
      off_in        = off_ff;
      slack_in      = slack_ff;
      any_free_in   = any_free_ff;
      n_in          = n_ff;
      last_in       = last_ff;
      tgt_in        = tgt_ff;
      cur_in        = cur_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      k_in          = k_ff;
      res_ok_in     = res_ok_ff;
      res_off_in    = res_off_ff;
      res_node_in   = res_node_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_node_in   = rsp_node_ff;
      // drop the output beat once it is taken
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff;
      ram_wdata     = 1'b0;
      ram_raddr     = cur_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep every entry to free, one per cycle
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = NODE_W'(clr_ff + NODE_W'(1));
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               cmd_in       = cmd_type'(req_bus.command);
               req_bytes_in = req_bus.request_bytes;
               align_in     = (req_bus.align_bytes == '0) ? BYTE_W'(1) : req_bus.align_bytes;
               lvl_in       = levels - LVL_W'(1);
               sat_in       = SAT_W'(leaf_bytes);
               tgt_in       = NODE_W'(req_bus.node_index);
               cur_in       = NODE_W'(req_bus.node_index);
               res_ok_in    = 1'b0;
               res_off_in   = '0;
               res_node_in  = '0;
               if (req_bus.command == CMD_FREE) begin
                  // a free echoes the node; out of range changes nothing
                  res_node_in = NODE_W'(req_bus.node_index);
                  if (NODE_W'(req_bus.node_index) < nodes) begin
                     res_ok_in = 1'b1;
                     state_in  = ST_FREE_UP;
                  end else begin
                     state_in  = ST_DONE;
                  end
               end else begin
                  state_in = ST_CHOOSE;
               end
            end
         end

         ST_CHOOSE: begin
            // climb from the leaf level until the node size covers the request
            if ({1'b0, req_bytes_ff} <= sat_ff) begin
               state_in = ST_LEVEL;
            end else if (lvl_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
               sat_in = sat_ff[SAT_W-1] ? sat_ff : {sat_ff[SAT_W-2:0], 1'b0};
            end
         end

         ST_LEVEL: begin
            // set up a level scan and start span mod align
            div_start   = 1'b1;
            span_in     = span_sel;
            base_end_in = OFF_W'(span_sel);
            off_in      = '0;
            slack_in    = '0;
            any_free_in = 1'b0;
            n_in        = level_first;
            last_in     = level_last;
            state_in    = ST_DIV;
         end

         ST_DIV: begin
            if (div_done) begin
               rs_in      = div_rem;
               span_fl_in = span_ff - div_rem;
               al_m_rs_in = align_ff - div_rem;
               state_in   = ST_PREP;
            end
         end

         ST_PREP: begin
            span_fl_al_in = OFF_W'(span_fl_ff) + OFF_W'(align_ff);
            state_in      = ST_SCAN_RD;
         end

         ST_SCAN_RD: begin
            ram_raddr = n_ff;
            state_in  = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            // read ahead the next node so the scan runs one node per cycle
            ram_raddr = NODE_W'(n_ff + NODE_W'(1));
            if (!ram_rdata[0] && fits) begin
               res_ok_in   = 1'b1;
               res_off_in  = off_ff[BYTE_W-1:0];
               res_node_in = n_ff;
               tgt_in      = n_ff;
               cur_in      = n_ff;
               state_in    = ST_MARK_RD;
            end else begin
               any_free_in = free_seen;
               if (n_ff == last_ff) begin
                  // free nodes but none aligned: retry one level up
                  if (free_seen && (lvl_ff != '0)) begin
                     lvl_in   = lvl_ff - LVL_W'(1);
                     state_in = ST_LEVEL;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  n_in        = NODE_W'(n_ff + NODE_W'(1));
                  base_end_in = base_end_ff + OFF_W'(span_ff);
                  off_in      = off_next;
                  slack_in    = slack_next;
               end
            end
         end

         ST_MARK_RD: begin
            ram_raddr = cur_ff;
            state_in  = ST_MARK_CHK;
         end

         ST_MARK_CHK: begin
            // mark the node and its ancestors busy until one already is
            if (ram_rdata[0]) begin
               lo_in    = {tgt_ff, 1'b1};
               hi_in    = NW1'({tgt_ff, 1'b0} + NW1'(2));
               k_in     = {tgt_ff, 1'b1};
               state_in = ST_BELOW;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = cur_ff;
               ram_wdata = 1'b1;
               if (cur_ff == '0) begin
                  lo_in    = {tgt_ff, 1'b1};
                  hi_in    = NW1'({tgt_ff, 1'b0} + NW1'(2));
                  k_in     = {tgt_ff, 1'b1};
                  state_in = ST_BELOW;
               end else begin
                  cur_in   = parent;
                  state_in = ST_MARK_RD;
               end
            end
         end

         ST_BELOW: begin
            // write every descendant, level by level, left to right
            if (k_ff >= NW1'(nodes)) begin
               state_in = ST_DONE;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = k_ff[NODE_W-1:0];
               ram_wdata = (cmd_ff == CMD_ALLOC);
               if (k_ff == hi_ff) begin
                  lo_in = {lo_ff[NODE_W-1:0], 1'b1};
                  hi_in = NW1'({hi_ff[NODE_W-1:0], 1'b0} + NW1'(2));
                  k_in  = {lo_ff[NODE_W-1:0], 1'b1};
               end else begin
                  k_in  = NW1'(k_ff + NW1'(1));
               end
            end
         end

         ST_FREE_UP: begin
            // clear this node and look at its buddy
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            ram_wdata = 1'b0;
            ram_raddr = buddy;
            if (cur_ff == '0) begin
               lo_in    = {tgt_ff, 1'b1};
               hi_in    = NW1'({tgt_ff, 1'b0} + NW1'(2));
               k_in     = {tgt_ff, 1'b1};
               state_in = ST_BELOW;
            end else begin
               state_in = ST_FREE_CHK;
            end
         end

         ST_FREE_CHK: begin
            // a busy buddy keeps the parent busy
            if (ram_rdata[0]) begin
               lo_in    = {tgt_ff, 1'b1};
               hi_in    = NW1'({tgt_ff, 1'b0} + NW1'(2));
               k_in     = {tgt_ff, 1'b1};
               state_in = ST_BELOW;
            end else begin
               cur_in   = parent;
               state_in = ST_FREE_UP;
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_off_in   = res_off_ff;
               rsp_node_in  = res_node_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // --- registers -----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         tree_levels_ff <= TREE_LEVELS_RST;
         pool_bytes_ff  <= POOL_BYTES_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               REG_TREE_LEVELS: tree_levels_ff <= csr_bus.data[LVL_CFG_W-1:0];
               REG_POOL_BYTES:  pool_bytes_ff  <= csr_bus.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      req_bytes_ff  <= req_bytes_in;
      align_ff      <= align_in;
      lvl_ff        <= lvl_in;
      sat_ff        <= sat_in;
      span_ff       <= span_in;
      rs_ff         <= rs_in;
      span_fl_ff    <= span_fl_in;
      al_m_rs_ff    <= al_m_rs_in;
      span_fl_al_ff <= span_fl_al_in;
      base_end_ff   <= base_end_in;
      off_ff        <= off_in;
      slack_ff      <= slack_in;
      any_free_ff   <= any_free_in;
      n_ff          <= n_in;
      last_ff       <= last_in;
      tgt_ff        <= tgt_in;
      cur_ff        <= cur_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      k_ff          <= k_in;
      res_ok_ff     <= res_ok_in;
      res_off_ff    <= res_off_in;
      res_node_ff   <= res_node_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_node_ff   <= rsp_node_in;
   end

   // --- busy-bit tree and remainder unit ------------------------------------
   bta_ram #(
      .WIDTH (1),
      .DEPTH (RAM_DEPTH)
   ) u_tree_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bta_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (span_sel),
      .divisor   (align_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // --- ports ---------------------------------------------------------------
   assign csr_bus.ready        = 1'b1;
   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ok           = rsp_ok_ff;
   assign rsp_bus.byte_offset  = rsp_off_ff;
   assign rsp_bus.granted_node = rsp_node_ff;

   // --- assertions ----------------------------------------------------------
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("command accepted while another is in flight");

   a_rem_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("remainder finished outside the level setup");

   a_scan_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_CHK |-> lvl_ff < LVL_W'(MAX_LEVELS))
      else $error("scan level outside the tree");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_off_ff == '0)
      else $error("failed response carries an offset");

endmodule
